// ----- rtl/core/iss_pkg.sv -----
// iss_pkg: shared constants and types of the indexed sequence store.
// Depends on nothing; imported by the interfaces, the cell and the core.
package iss_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned OpW         = 3;
  localparam int unsigned PosW        = 8;
  localparam int unsigned StW         = 2;
  localparam int unsigned CapacityDef = 64;

  localparam logic [OpW-1:0] OpRead      = 3'd0;
  localparam logic [OpW-1:0] OpInsFront  = 3'd1;
  localparam logic [OpW-1:0] OpInsBack   = 3'd2;
  localparam logic [OpW-1:0] OpInsAt     = 3'd3;
  localparam logic [OpW-1:0] OpDelAt     = 3'd4;

  localparam logic [StW-1:0] StDone  = 2'd0;
  localparam logic [StW-1:0] StRange = 2'd1;
  localparam logic [StW-1:0] StFull  = 2'd2;

  // per-cell control for one cycle
  typedef struct packed {
    logic load;        // take the incoming value
    logic from_left;   // shift toward the back
    logic from_right;  // shift toward the front
    logic hit;         // drive own entry onto the read bus
  } cell_ctl_t;

endpackage

// ----- rtl/core/iss_if.sv -----
// iss_in_if / iss_out_if: valid-ready channels of the indexed sequence store.
// Depends on iss_pkg for field widths.
interface iss_in_if
  import iss_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         op;
  logic signed [PosW-1:0] position;
  logic signed [DataW-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

interface iss_out_if
  import iss_pkg::*;
#(
  parameter int unsigned LenW = 7
) ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] read_value;
  logic [StW-1:0]          status;
  logic [LenW-1:0]         length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink   (input valid, read_value, status, length, output ready);
endinterface

// ----- rtl/core/indexed_sequence_store_core.sv -----
// indexed_sequence_store_core: top level, operation decode, row of entry cells, result register.
// Depends on iss_pkg, iss_if (iss_in_if, iss_out_if) and iss_cell.
//
//  channel | dir | payload                          | handshake
//  in_i    | in  | op, position, value              | valid/ready
//  out_o   | out | read_value, status, length       | valid/ready
//
// Decode and the parallel shift of the cell row happen at the accepting edge,
// and the result is loaded into the output register at that same edge.
// in_i.ready is high while the output register is empty or being drained, so a
// word is taken every cycle when out_o is not stalled.
// Reset clears the length and the output valid; entry contents are not reset.
module indexed_sequence_store_core
  import iss_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned LenW     = $clog2(Capacity + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  iss_in_if.sink    in_i,
  iss_out_if.source out_o
);

  localparam int unsigned CmpW = (LenW > PosW - 1) ? LenW : PosW - 1;
  localparam logic [LenW-1:0] CapLen = LenW'(Capacity);

  logic [LenW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [DataW-1:0] rd_value_q, rd_value_d;
  logic [StW-1:0]   status_q, status_d;

  logic accept;
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  // decode
  logic            pos_neg;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            in_range, is_ins, ins_beyond, full, do_ins, do_del, do_rd;
  logic [LenW-1:0] slot;

  assign pos_neg  = in_i.position[PosW-1];
  assign pos_ext  = CmpW'(in_i.position[PosW-2:0]);
  assign cnt_ext  = CmpW'(count_q);
  assign in_range = ~pos_neg & (pos_ext < cnt_ext);
  assign full     = (count_q == CapLen);
  assign is_ins   = (in_i.op == OpInsFront) | (in_i.op == OpInsBack) | (in_i.op == OpInsAt);
  assign ins_beyond = (in_i.op == OpInsAt) & ~pos_neg & (pos_ext > cnt_ext);
  assign do_ins   = accept & is_ins & ~ins_beyond & ~full;
  assign do_del   = accept & (in_i.op == OpDelAt) & in_range;
  assign do_rd    = (in_i.op == OpRead) & in_range;

  always_comb begin
    priority if (in_i.op == OpInsFront) begin
      slot = '0;
    end else if (in_i.op == OpInsBack) begin
      slot = count_q;
    end else if ((in_i.op == OpInsAt) && pos_neg) begin
      slot = '0;
    end else begin
      slot = LenW'(pos_ext);
    end
  end

  // cell row
  logic [DataW-1:0] cell_data [Capacity];
  logic [DataW-1:0] cell_rd   [Capacity];
  logic [DataW-1:0] rd_bus;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    localparam logic [LenW-1:0] Idx = LenW'(g);
    cell_ctl_t        ctl;
    logic [DataW-1:0] left, right;

    assign ctl.load       = do_ins & (Idx == slot);
    assign ctl.from_left  = do_ins & (Idx > slot);
    assign ctl.from_right = do_del & (Idx >= slot);
    assign ctl.hit        = do_rd & (Idx == slot);

    if (g == 0) begin : g_first
      assign left = in_i.value;
    end else begin : g_mid
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_inner
      assign right = cell_data[g+1];
    end

    iss_cell #(
      .Width(DataW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .new_i  (in_i.value),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g]),
      .rd_o   (cell_rd[g])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < Capacity; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // result
  always_comb begin
    count_d    = count_q;
    rd_value_d = '0;
    status_d   = StDone;
    if (do_ins) begin
      count_d = count_q + LenW'(1);
    end else if (do_del) begin
      count_d = count_q - LenW'(1);
    end
    unique case (in_i.op)
      OpRead: begin
        if (in_range) begin
          rd_value_d = rd_bus;
        end else begin
          rd_value_d = '1;
          status_d   = StRange;
        end
      end
      OpInsFront, OpInsBack, OpInsAt: begin
        if (ins_beyond) begin
          status_d = StRange;
        end else if (full) begin
          status_d = StFull;
        end
      end
      OpDelAt: begin
        if (!in_range) begin
          status_d = StRange;
        end
      end
      default: status_d = StRange;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (in_i.ready) begin
        out_valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_value_q <= rd_value_d;
      status_q   <= status_d;
    end
  end

  logic [LenW-1:0] len_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_q <= count_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = rd_value_q;
  assign out_o.status     = status_q;
  assign out_o.length     = len_q;

endmodule

// ----- rtl/core/iss_cell.sv -----
// iss_cell: one entry of the sequence; loads, shifts from either neighbor or holds.
// Depends on iss_pkg (cell_ctl_t).
module iss_cell
  import iss_pkg::*;
#(
  parameter int unsigned Width = DataW
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [Width-1:0] new_i,
  input  logic [Width-1:0] left_i,
  input  logic [Width-1:0] right_i,
  output logic [Width-1:0] data_o,
  output logic [Width-1:0] rd_o
);

  logic [Width-1:0] data_q, data_d;

  always_comb begin
    priority if (ctl_i.load) begin
      data_d = new_i;
    end else if (ctl_i.from_left) begin
      data_d = left_i;
    end else if (ctl_i.from_right) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  // entry content is undefined until written, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = ctl_i.hit ? data_q : '0;

endmodule

// ----- bench/tb_indexed_sequence_store_core.sv -----
// tb_indexed_sequence_store_core: self-checking bench for the indexed sequence store.
// Depends on iss_pkg, iss_in_if / iss_out_if and indexed_sequence_store_core.
// A directed table runs first, then random words checked against a local predictor.
`timescale 1ns / 1ps

module tb_indexed_sequence_store_core;
  import iss_pkg::*;

  localparam int unsigned Capacity    = CapacityDef;
  localparam int unsigned LenW        = $clog2(Capacity + 1);
  localparam int          RandomWords = 800;
  localparam int          HoldCycles  = 400;
  localparam int          HoldAfter   = 300;
  localparam int          TailCycles  = 8;
  localparam int          QuietLimit  = 2000;

  localparam logic [OpW-1:0] OpFirstUnused = 3'd5;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [StW-1:0]          status;
    logic [LenW-1:0]         length;
  } result_t;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [PosW-1:0]  pos;
    logic signed [DataW-1:0] val;
    logic                    fixed;  // res holds the expected word
    result_t                 res;
  } stim_row_t;

  typedef enum int {MixFill, MixBalanced, MixDrain} mix_mode_e;
  typedef enum int {RxAlways, RxMostly, RxSparse, RxPeriodic} rx_style_e;

  logic clk_i;
  logic rst_ni;

  iss_in_if                 in_if ();
  iss_out_if #(.LenW(LenW)) out_if ();

  indexed_sequence_store_core #(
    .Capacity(Capacity),
    .LenW    (LenW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predicted contents of the store
  logic signed [DataW-1:0] store_data [Capacity];
  int                      store_len;

  result_t pending_results [$];
  int      mismatches;
  int      results_seen;
  int      burst_left;

  localparam result_t NoResult = '0;

  stim_row_t dir_rows [0:23] = '{
    '{OpRead,        8'sd0,   32'sd0,          1'b1, '{-32'sd1, StRange, 7'd0}},
    '{OpDelAt,       8'sd0,   32'sd0,          1'b1, '{32'sd0,  StRange, 7'd0}},
    '{OpInsAt,       8'sd1,   32'sd9,          1'b1, '{32'sd0,  StRange, 7'd0}},
    '{OpFirstUnused, 8'sd0,   32'sd1,          1'b1, '{32'sd0,  StRange, 7'd0}},
    '{OpFirstUnused + 3'd1, 8'sd0, 32'sd1,     1'b1, '{32'sd0,  StRange, 7'd0}},
    '{OpFirstUnused + 3'd2, 8'shFF, -32'sd1,   1'b1, '{32'sd0,  StRange, 7'd0}},
    '{OpInsFront,    8'sd0,   32'sh7FFF_FFFF,  1'b1, '{32'sd0,  StDone,  7'd1}},
    '{OpInsBack,     8'sd0,   32'sh8000_0000,  1'b1, '{32'sd0,  StDone,  7'd2}},
    '{OpInsAt,       8'sh80,  -32'sd1,         1'b1, '{32'sd0,  StDone,  7'd3}},
    '{OpInsAt,       8'sd3,   32'sd0,          1'b1, '{32'sd0,  StDone,  7'd4}},
    '{OpInsAt,       8'sd2,   32'sh5555_5555,  1'b0, NoResult},
    '{OpRead,        8'sd0,   32'sd0,          1'b0, NoResult},
    '{OpRead,        8'shFF,  32'sd0,          1'b1, '{-32'sd1, StRange, 7'd5}},
    '{OpRead,        8'sd127, 32'sd0,          1'b1, '{-32'sd1, StRange, 7'd5}},
    '{OpRead,        8'sd4,   32'sd0,          1'b0, NoResult},
    '{OpDelAt,       8'sd127, 32'sd0,          1'b1, '{32'sd0,  StRange, 7'd5}},
    '{OpDelAt,       8'sh80,  32'sd0,          1'b1, '{32'sd0,  StRange, 7'd5}},
    '{OpDelAt,       8'sd0,   32'sd0,          1'b0, NoResult},
    '{OpInsAt,       8'sd127, 32'sd5,          1'b1, '{32'sd0,  StRange, 7'd4}},
    '{OpInsAt,       8'sd1,   32'shAAAA_AAAA,  1'b0, NoResult},
    '{OpRead,        8'sd1,   32'sd0,          1'b0, NoResult},
    '{OpDelAt,       8'sd4,   32'sd0,          1'b0, NoResult},
    '{OpRead,        8'sd3,   32'sd0,          1'b0, NoResult},
    '{OpInsAt,       8'sd4,   32'sh0000_FFFF,  1'b0, NoResult}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // applies one word to the predicted store and returns the word it should give back
  function automatic result_t apply_word(input logic [OpW-1:0] op,
                                         input logic signed [PosW-1:0] pos,
                                         input logic signed [DataW-1:0] val);
    result_t r;
    int      p;
    int      slot;
    int      i;
    r.read_value = '0;
    r.status     = StDone;
    p            = int'(pos);
    slot         = -1;
    case (op)
      OpRead: begin
        if (p >= 0 && p < store_len) begin
          r.read_value = store_data[p];
        end else begin
          r.read_value = -32'sd1;
          r.status     = StRange;
        end
      end
      OpInsFront: slot = 0;
      OpInsBack:  slot = store_len;
      OpInsAt: begin
        if (p < 0) slot = 0;
        else if (p > store_len) r.status = StRange;
        else slot = p;
      end
      OpDelAt: begin
        if (p >= 0 && p < store_len) begin
          for (i = p; i < store_len - 1; i++) store_data[i] = store_data[i + 1];
          store_len--;
        end else begin
          r.status = StRange;
        end
      end
      default: r.status = StRange;
    endcase
    // range check above wins over the full check
    if (slot >= 0) begin
      if (store_len >= Capacity) begin
        r.status = StFull;
      end else begin
        for (i = store_len; i > slot; i--) store_data[i] = store_data[i - 1];
        store_data[slot] = val;
        store_len++;
      end
    end
    r.length = LenW'(store_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h (result word %0d)",
             $realtime, what, got, want, results_seen);
    mismatches++;
  endtask

  // offers one word in bursts with random gaps; predicts it once it is taken
  task automatic send_word(input logic [OpW-1:0] op, input logic signed [PosW-1:0] pos,
                           input logic signed [DataW-1:0] val, input logic fixed,
                           input result_t fixed_res);
    result_t predicted;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= op;
    in_if.position <= pos;
    in_if.value    <= val;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = apply_word(op, pos, val);
    pending_results.push_back(fixed ? fixed_res : predicted);
    burst_left--;
  endtask

  initial begin : stimulus
    stim_row_t         row;
    logic [OpW-1:0]    op;
    logic signed [PosW-1:0]  pos;
    logic signed [DataW-1:0] val;
    mix_mode_e         mode;
    mix_mode_e         phase_order [4];
    int                counted;
    int                seg_left;
    int                phase;
    int                roll;
    int                read_end;
    int                ins_end;
    bit                paused;

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.op       = OpRead;
    in_if.position = '0;
    in_if.value    = '0;
    store_len      = 0;
    mismatches     = 0;
    results_seen   = 0;
    burst_left     = 0;
    phase_order    = '{MixFill, MixBalanced, MixDrain, MixBalanced};
    mode           = MixFill;
    counted        = 0;
    seg_left       = 0;
    phase          = 0;
    paused         = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_word(row.op, row.pos, row.val, row.fixed, row.res);
    end

    while (counted < RandomWords) begin
      if (seg_left == 0) begin
        mode     = phase_order[phase % 4];
        phase++;
        seg_left = $urandom_range(60, 110);
      end
      // one full drain of the result side partway through
      if (!paused && counted == RandomWords / 2) begin
        paused      = 1'b1;
        in_if.valid <= 1'b0;
        burst_left  = 0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end

      case (mode)
        MixFill:  begin read_end = 10; ins_end = 92; end
        MixDrain: begin read_end = 15; ins_end = 25; end
        default:  begin read_end = 30; ins_end = 65; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OpFirstUnused + OpW'($urandom_range(0, 2));
      else if (roll < read_end) op = OpRead;
      else if (roll < ins_end) begin
        case ($urandom_range(0, 3))
          0:       op = OpInsFront;
          1:       op = OpInsBack;
          default: op = OpInsAt;
        endcase
      end else op = OpDelAt;

      pos = PosW'($urandom);
      if ((op == OpRead || op == OpDelAt) && store_len > 0 && $urandom_range(0, 4) != 0) begin
        pos = PosW'($urandom_range(0, store_len - 1));
      end else if (op == OpInsAt) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) pos = PosW'($urandom_range(0, store_len));
        else if (roll < 8) pos = PosW'($urandom_range(128, 255));
      end

      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = 32'sd0;
          1:       val = -32'sd1;
          2:       val = 32'sh7FFF_FFFF;
          default: val = 32'sh8000_0000;
        endcase
      end else begin
        val = $urandom;
      end

      send_word(op, pos, val, 1'b0, NoResult);
      if (op <= OpDelAt) begin
        counted++;
        seg_left--;
      end
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      report_mismatch("words never returned", pending_results.size(), '0);
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected", out_if.read_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_value !== want.read_value)
          report_mismatch("read_value", out_if.read_value, want.read_value);
        if (out_if.status !== want.status)
          report_mismatch("status", DataW'(out_if.status), DataW'(want.status));
        if (out_if.length !== want.length)
          report_mismatch("length", DataW'(out_if.length), DataW'(want.length));
      end
    end
  end

  // receiver stalls: a style picked per stretch, plus one long hold-off to back up the input
  always @(posedge clk_i) begin : rx_stall
    static rx_style_e style     = RxAlways;
    static int        style_left = 0;
    static int        hold_left  = 0;
    static bit        hold_done  = 1'b0;
    static int        cyc        = 0;
    logic             rdy;
    cyc++;
    if (style_left == 0) begin
      style      = rx_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(20, 120);
    end
    style_left--;
    if (!hold_done && results_seen >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      case (style)
        RxAlways:   rdy = 1'b1;
        RxMostly:   rdy = ($urandom_range(0, 3) != 0);
        RxSparse:   rdy = ($urandom_range(0, 9) < 3);
        default:    rdy = ((cyc % 8) != 0);
      endcase
    end
    out_if.ready <= rdy;
  end

  always @(posedge clk_i) begin : watchdog
    static int quiet_cycles = 0;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ----- indexed_sequence_store_core.f -----
rtl/core/iss_pkg.sv
rtl/core/iss_if.sv
rtl/core/iss_cell.sv
rtl/core/indexed_sequence_store_core.sv
bench/tb_indexed_sequence_store_core.sv
